// ===== rtl/ptl_pkg.sv =====
// Shared types and constants for the Phong and toon pixel lighting unit.
// Used by the vector normalizer and the top level; no dependencies.
package ptl_pkg;

  // Normalized vector component, Q1.16 signed.
  typedef logic signed [17:0] unit_t;

  // Lighting mode register values.
  typedef enum logic {
    MODE_PHONG = 1'b0,
    MODE_TOON  = 1'b1
  } mode_e;

  // Configuration register indexes.
  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_DESAT = 1'b1;

  // Normalizer depth: squares, sum, square root steps, divider steps.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 17;
  localparam int NORM_LAT   = SQRT_STEPS + DIV_STEPS + 2;

  // Stages after the normalizers, the output register included.
  localparam int POST_LAT   = 12;
  localparam int SQUARINGS  = 5;

  // Toon thresholds on n.l in Q.32.
  localparam logic signed [35:0] TOON_T0 = 36'sd4209067950;
  localparam logic signed [35:0] TOON_T1 = 36'sd3865470566;
  localparam logic signed [35:0] TOON_T2 = 36'sd2147483648;
  localparam logic signed [35:0] TOON_T3 = 36'sd1073741824;

  // Toon rounding: the denominator is 2^22 * 3125.
  localparam logic [49:0] TOON_HALF  = 50'd6553600000;
  localparam logic [28:0] TOON_RECIP = 29'd351843721;

  // Side data that travels with a vector through the normalizer.
  typedef struct packed {
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic             zero;
  } nside_t;

endpackage

// ===== rtl/phong_and_toon_pixel_lighting_unit.sv =====
// Per-pixel Phong / toon lighting unit, top level.
// Depends on ptl_pkg and three ptl_norm vector normalizers.
//
// The unit takes one pixel transaction per clock while no finished result
// is held and returns one lit color per transaction, in order, after the
// vector normalizers (the 32-step square root and the 17-step divider) and
// the stages of dot products, reflection, five squarings for the specular
// power and the color mix. The whole pipeline freezes while a finished
// result is held by out_stall_i; bubbles move on otherwise. Registers
// lighting_mode and desaturation must only be written while no transaction
// is in flight.
module phong_and_toon_pixel_lighting_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic signed [15:0] light_x_i,
  input  logic signed [15:0] light_y_i,
  input  logic signed [15:0] light_z_i,
  input  logic signed [15:0] view_x_i,
  input  logic signed [15:0] view_y_i,
  input  logic signed [15:0] view_z_i,
  input  logic [15:0]        base_red_i,
  input  logic [15:0]        base_green_i,
  input  logic [15:0]        base_blue_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        lit_red_o,
  output logic [15:0]        lit_green_o,
  output logic [15:0]        lit_blue_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [16:0]        cfg_wdata_i
);
  import ptl_pkg::*;

  logic  en;
  mode_e mode_q;
  logic [16:0] desat_q, t_sat, t_inv;

  unit_t nu [3];
  unit_t lu [3];
  unit_t vu [3];

  // Valid line and color line alongside the normalizers.
  logic             vld_q [NORM_LAT];
  logic [2:0][15:0] col_q [NORM_LAT];
  logic             vpost_q [POST_LAT];

  // Post-normalizer stage registers.
  logic signed [35:0] s1_nl_q [3];
  unit_t              s1_n_q [3], s1_l_q [3], s1_v_q [3];
  logic [2:0][15:0]   s1_c_q;
  logic [29:0]        s1_luma_q;
  logic [2:0][29:0]   s1_cw_q;

  logic signed [35:0] s2_nl_q;
  unit_t              s2_n_q [3], s2_l_q [3], s2_v_q [3];
  logic [2:0][15:0]   s2_c_q;
  logic [29:0]        s2_luma_q;
  logic [2:0][29:0]   s2_cw_q;

  logic signed [53:0] s3_nn_q [3];
  logic [32:0]        s3_d_q;
  logic [3:0]         s3_g_q;
  logic [2:0][46:0]   s3_tb_q;
  unit_t              s3_l_q [3], s3_v_q [3];
  logic [2:0][15:0]   s3_c_q;

  logic signed [23:0] s4_r_q [3];
  logic [2:0][27:0]   s4_y_q;
  logic [2:0][48:0]   s4_dc_q;
  unit_t              s4_v_q [3];
  logic [2:0][15:0]   s4_c_q;

  logic signed [41:0] s5_rv_q [3];
  logic [2:0][56:0]   s5_tq_q;
  logic [2:0][51:0]   s5_base_q;

  logic [31:0]        p_q    [SQUARINGS+1];
  logic [2:0][51:0]   base_q [SQUARINGS+1];
  logic [2:0][15:0]   toon_q [SQUARINGS+1];

  // Global advance: the pipeline moves unless a result is held.
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_PHONG;
      desat_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:  mode_q  <= mode_e'(cfg_wdata_i[0]);
        CFG_DESAT: desat_q <= cfg_wdata_i;
        default:   mode_q  <= mode_q;
      endcase
    end
  end

  assign t_sat = (desat_q > 17'd65536) ? 17'd65536 : desat_q;
  assign t_inv = 17'(17'd65536 - t_sat);

  ptl_norm u_norm_n (
    .clk_i (clk_i), .en_i (en),
    .x_i (normal_x_i), .y_i (normal_y_i), .z_i (normal_z_i),
    .ux_o (nu[0]), .uy_o (nu[1]), .uz_o (nu[2])
  );

  ptl_norm u_norm_l (
    .clk_i (clk_i), .en_i (en),
    .x_i (light_x_i), .y_i (light_y_i), .z_i (light_z_i),
    .ux_o (lu[0]), .uy_o (lu[1]), .uz_o (lu[2])
  );

  ptl_norm u_norm_v (
    .clk_i (clk_i), .en_i (en),
    .x_i (view_x_i), .y_i (view_y_i), .z_i (view_z_i),
    .ux_o (vu[0]), .uy_o (vu[1]), .uz_o (vu[2])
  );

  // Valid bits for every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NORM_LAT; k++) vld_q[k] <= 1'b0;
      for (int k = 0; k < POST_LAT; k++) vpost_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < NORM_LAT; k++) vld_q[k] <= vld_q[k-1];
      vpost_q[0] <= vld_q[NORM_LAT-1];
      for (int k = 1; k < POST_LAT; k++) vpost_q[k] <= vpost_q[k-1];
    end
  end

  assign out_valid_o = vpost_q[POST_LAT-1];

  // Colors wait while the vectors are normalized.
  always_ff @(posedge clk_i) begin
    if (en) begin
      col_q[0] <= {base_blue_i, base_green_i, base_red_i};
      for (int k = 1; k < NORM_LAT; k++) col_q[k] <= col_q[k-1];
    end
  end

  // Stage 1: n.l products, luma and scaled colors.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_nl_q[i] <= 36'(nu[i]) * 36'(lu[i]);
        s1_n_q[i]  <= nu[i];
        s1_l_q[i]  <= lu[i];
        s1_v_q[i]  <= vu[i];
        s1_cw_q[i] <= 30'(30'(col_q[NORM_LAT-1][i]) * 30'd10000);
      end
      s1_c_q    <= col_q[NORM_LAT-1];
      s1_luma_q <= 30'(30'(col_q[NORM_LAT-1][0]) * 30'd2126
                      + 30'(col_q[NORM_LAT-1][1]) * 30'd7152
                      + 30'(col_q[NORM_LAT-1][2]) * 30'd722);
    end
  end

  // Stage 2: n.l sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_nl_q   <= s1_nl_q[0] + s1_nl_q[1] + s1_nl_q[2];
      s2_n_q    <= s1_n_q;
      s2_l_q    <= s1_l_q;
      s2_v_q    <= s1_v_q;
      s2_c_q    <= s1_c_q;
      s2_luma_q <= s1_luma_q;
      s2_cw_q   <= s1_cw_q;
    end
  end

  // Stage 3: reflection products, diffuse clamp, toon gain and blend.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_nn_q[i] <= 54'(s2_nl_q) * 54'(s2_n_q[i]);
        s3_tb_q[i] <= 47'(s2_cw_q[i]) * 47'(t_inv) + 47'(s2_luma_q) * 47'(t_sat);
      end
      if (s2_nl_q < 36'sd0) begin
        s3_d_q <= '0;
      end else if (s2_nl_q > 36'sd4294967296) begin
        s3_d_q <= 33'h1_0000_0000;
      end else begin
        s3_d_q <= 33'(s2_nl_q);
      end
      if (s2_nl_q > TOON_T0) begin
        s3_g_q <= 4'd15;
      end else if (s2_nl_q > TOON_T1) begin
        s3_g_q <= 4'd10;
      end else if (s2_nl_q > TOON_T2) begin
        s3_g_q <= 4'd6;
      end else if (s2_nl_q > TOON_T3) begin
        s3_g_q <= 4'd4;
      end else begin
        s3_g_q <= 4'd2;
      end
      s3_l_q <= s2_l_q;
      s3_v_q <= s2_v_q;
      s3_c_q <= s2_c_q;
    end
  end

  // Stage 4: reflection vector, toon numerator, diffuse term.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [53:0] adj;
        adj = s3_nn_q[i] + (s3_nn_q[i][53] ? 54'sd2147483647 : 54'sd0);
        s4_r_q[i]  <= 24'(adj >>> 31) - 24'(s3_l_q[i]);
        s4_y_q[i]  <= 28'((50'(s3_tb_q[i]) * 50'(s3_g_q) + TOON_HALF) >> 22);
        s4_dc_q[i] <= 49'(s3_d_q) * 49'(s3_c_q[i]);
      end
      s4_v_q <= s3_v_q;
      s4_c_q <= s3_c_q;
    end
  end

  // Stage 5: r.v products, toon division by reciprocal, Phong base sum.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_rv_q[i]   <= 42'(s4_r_q[i]) * 42'(s4_v_q[i]);
        s5_tq_q[i]   <= 57'(s4_y_q[i]) * 57'(TOON_RECIP);
        s5_base_q[i] <= {4'b0, s4_c_q[i], 32'b0} + 52'(s4_dc_q[i]) * 52'd7;
      end
    end
  end

  // Stage 6: r.v sum and clamp, toon saturation.
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic signed [43:0] rv;
      rv = 44'(s5_rv_q[0]) + 44'(s5_rv_q[1]) + 44'(s5_rv_q[2]);
      if (rv < 44'sd0) begin
        p_q[0] <= '0;
      end else if (rv > 44'sd4294967296) begin
        p_q[0] <= 32'h8000_0000;
      end else begin
        p_q[0] <= 32'(rv >>> 1);
      end
      for (int i = 0; i < 3; i++) begin
        toon_q[0][i] <= (s5_tq_q[i][56:40] > 17'd65535) ? 16'hFFFF : s5_tq_q[i][55:40];
      end
      base_q[0] <= s5_base_q;
    end
  end

  // Stages 7 to 11: specular power by five rounded squarings.
  for (genvar k = 1; k <= SQUARINGS; k++) begin : g_pow
    logic [63:0] sq;
    assign sq = 64'(p_q[k-1]) * 64'(p_q[k-1]) + 64'h4000_0000;
    always_ff @(posedge clk_i) begin
      if (en) begin
        p_q[k]    <= sq[62:31];
        base_q[k] <= base_q[k-1];
        toon_q[k] <= toon_q[k-1];
      end
    end
  end

  // Stage 12: Phong rounding and the mode select into the output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      logic [53:0] acc [3];
      logic [15:0] res [3];
      for (int i = 0; i < 3; i++) begin
        acc[i] = 54'(base_q[SQUARINGS][i]) + ((54'(p_q[SQUARINGS]) * 54'd3) << 16)
                 + 54'h4_0000_0000;
        res[i] = (acc[i][53:35] > 19'd65535) ? 16'hFFFF : acc[i][50:35];
        if (mode_q == MODE_TOON) begin
          res[i] = toon_q[SQUARINGS][i];
        end
      end
      lit_red_o   <= res[0];
      lit_green_o <= res[1];
      lit_blue_o  <= res[2];
    end
  end

  // The input is held back only while a finished result is waiting.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a held result");

  // A held result freezes the valid bits behind it; vld_q[0], vpost_q[0] and vpost_q[POST_LAT-2] are checked.
  a_frozen_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(vld_q[0]) && $stable(vpost_q[0])
      && $stable(vpost_q[POST_LAT-2])))
    else $error("pipeline moved while its result was held");

endmodule

// ===== rtl/ptl_norm.sv =====
// Pipelined vector normalizer: squared length, bit-per-stage square root and
// bit-per-stage restoring division of each component. Depends on ptl_pkg.
module ptl_norm (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [15:0]  x_i,
  input  logic signed [15:0]  y_i,
  input  logic signed [15:0]  z_i,
  output ptl_pkg::unit_t      ux_o,
  output ptl_pkg::unit_t      uy_o,
  output ptl_pkg::unit_t      uz_o
);
  import ptl_pkg::*;

  logic signed [15:0] comp [3];
  logic [2:0][31:0]   sq_d, sq_q;
  nside_t             s0_d, s0_q, s1_q;
  logic [31:0]        len_q;

  logic [63:0]        sv_q  [SQRT_STEPS];
  logic [63:0]        sr_q  [SQRT_STEPS];
  nside_t             ss_q  [SQRT_STEPS];

  logic [2:0][47:0]   rem_q [DIV_STEPS];
  logic [2:0][16:0]   quo_q [DIV_STEPS];
  logic [31:0]        ds_q  [DIV_STEPS];
  nside_t             dside_q [DIV_STEPS];

  unit_t              u [3];

  assign comp[0] = x_i;
  assign comp[1] = y_i;
  assign comp[2] = z_i;

  // Magnitudes, signs and squares of the raw components.
  always_comb begin
    s0_d = '0;
    for (int i = 0; i < 3; i++) begin
      s0_d.neg[i] = comp[i][15];
      s0_d.mag[i] = comp[i][15] ? 16'(-comp[i]) : 16'(comp[i]);
      sq_d[i]     = 32'(s0_d.mag[i]) * 32'(s0_d.mag[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
      s0_q <= s0_d;
    end
  end

  // Squared length; a zero vector is flagged here.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q <= 32'(sq_q[0] + sq_q[1] + sq_q[2]);
      s1_q  <= {s0_q.mag, s0_q.neg, (32'(sq_q[0] + sq_q[1] + sq_q[2]) == 32'd0)};
    end
  end

  // Square root of len * 2^32, one result bit per stage.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BitK = 64'(1) << (62 - 2 * k);
    logic [63:0] v_in, r_in, v_d, r_d, trial;
    nside_t      sd_in;

    if (k == 0) begin : g_first
      assign v_in  = {len_q, 32'b0};
      assign r_in  = '0;
      assign sd_in = s1_q;
    end else begin : g_next
      assign v_in  = sv_q[k-1];
      assign r_in  = sr_q[k-1];
      assign sd_in = ss_q[k-1];
    end

    always_comb begin
      trial = r_in + BitK;
      if (v_in >= trial) begin
        v_d = v_in - trial;
        r_d = (r_in >> 1) + BitK;
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sv_q[k] <= v_d;
        sr_q[k] <= r_d;
        ss_q[k] <= sd_in;
      end
    end
  end

  // Component magnitude * 2^32 / root, one quotient bit per stage.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int Sh = DIV_STEPS - 1 - j;
    logic [2:0][47:0] rem_in, rem_d;
    logic [2:0][16:0] quo_in, quo_d;
    logic [31:0]      s_in;
    logic [48:0]      dsh;
    nside_t           sd_in;

    if (j == 0) begin : g_first
      assign s_in  = sr_q[SQRT_STEPS-1][31:0];
      assign sd_in = ss_q[SQRT_STEPS-1];
      assign quo_in = '0;
      for (genvar i = 0; i < 3; i++) begin : g_rem
        assign rem_in[i] = {ss_q[SQRT_STEPS-1].mag[i], 32'b0};
      end
    end else begin : g_next
      assign s_in   = ds_q[j-1];
      assign sd_in  = dside_q[j-1];
      assign quo_in = quo_q[j-1];
      assign rem_in = rem_q[j-1];
    end

    always_comb begin
      dsh = 49'(s_in) << Sh;
      for (int i = 0; i < 3; i++) begin
        if (49'(rem_in[i]) >= dsh) begin
          rem_d[i] = 48'(49'(rem_in[i]) - dsh);
          quo_d[i] = {quo_in[i][15:0], 1'b1};
        end else begin
          rem_d[i] = rem_in[i];
          quo_d[i] = {quo_in[i][15:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]   <= rem_d;
        quo_q[j]   <= quo_d;
        ds_q[j]    <= s_in;
        dside_q[j] <= sd_in;
      end
    end
  end

  // Limit to one, restore the sign; a zero vector stays zero.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [16:0] m;
      m = (quo_q[DIV_STEPS-1][i] > 17'd65536) ? 17'd65536 : quo_q[DIV_STEPS-1][i];
      if (dside_q[DIV_STEPS-1].zero) begin
        m = '0;
      end
      u[i] = dside_q[DIV_STEPS-1].neg[i] ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  end

  assign ux_o = u[0];
  assign uy_o = u[1];
  assign uz_o = u[2];

endmodule
